// ----- rtl/shq_pkg.sv -----
package shq_pkg;

    // field and result widths
    localparam int FIELD_W        = 14;
    localparam int THR_W          = 28;
    localparam int COEF_W         = 32;
    localparam int NUM_COEF       = 8;
    localparam int COORD_BITS_DEF = 14;

    // fixed point: Q.4 coordinates, Q.16 coefficients, Q.20 products
    localparam int FRAC_W    = 16;
    localparam int IN_SHIFT  = 12;
    localparam int RND_SHIFT = 4;
    localparam int QUO_W     = 32;

    localparam logic [THR_W-1:0]         THR_RESET = 28'd16;
    localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh8000_0000;

    // control that travels with an item between the pipeline parts
    typedef struct packed {
        logic vld;
        logic aff;
    } t_ctl;

endpackage

// ----- rtl/square_to_quad_homography_top.sv -----
// channel   | dir | payload                                   | flow
// s_axis    | in  | tdata: bl, br, tr, tl corners (col, row)  | tvalid / tready
// m_axis    | out | tdata: coef a..h, tuser: affine, clipped  | tvalid / tready
// cfg       | in  | affine threshold, 28 bits                 | write enable only
//
// one request enters per cycle unless the output waits and stalls the pipeline
// 41 register stages: the 32-step restoring quotient pipeline plus 9 arithmetic stages
// reset is synchronous and active low; it clears valid bits and loads threshold 16
// one shared advance enable stalls every stage while the output waits, nothing is lost
module square_to_quad_homography_top #(
    parameter int COORD_BITS = shq_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // bl_col, bl_row, br_col, br_row, tr_col, tr_row, tl_col, tl_row
    input  logic [111:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, coef_g, coef_h
    output logic [255:0]   m_axis_tdata,
    output logic [1:0]     m_axis_tuser,   // is_affine, saturated
    input  logic           i_cfg_wr_en,
    input  logic [shq_pkg::THR_W-1:0] i_cfg_wr_data
);

    localparam int FW  = shq_pkg::FIELD_W;
    localparam int UW  = (COORD_BITS < FW) ? COORD_BITS : FW;
    localparam int NW  = 2 * UW + 22;
    localparam int DW  = 2 * UW + 3;
    localparam int SBW = 6 * UW + 3;

    // threshold register
    logic [shq_pkg::THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= shq_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // pipeline advances whenever the output register is free or drained
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;

    // front: differences, cross products, magnitudes
    shq_pkg::t_ctl   w_ctl_f;
    logic [6*UW-1:0] w_crd_f;
    logic [NW-1:0]   w_num_g, w_num_h;
    logic [DW-1:0]   w_den;
    logic            w_ng_f, w_nh_f, w_og_f, w_oh_f;

    shq_front #(.UW(UW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_x0    (s_axis_tdata[0*FW +: UW]),
        .i_y0    (s_axis_tdata[1*FW +: UW]),
        .i_x1    (s_axis_tdata[2*FW +: UW]),
        .i_y1    (s_axis_tdata[3*FW +: UW]),
        .i_x2    (s_axis_tdata[4*FW +: UW]),
        .i_y2    (s_axis_tdata[5*FW +: UW]),
        .i_x3    (s_axis_tdata[6*FW +: UW]),
        .i_y3    (s_axis_tdata[7*FW +: UW]),
        .i_thr   (r_thr),
        .o_ctl   (w_ctl_f),
        .o_crd   (w_crd_f),
        .o_num_g (w_num_g),
        .o_num_h (w_num_h),
        .o_den   (w_den),
        .o_neg_g (w_ng_f),
        .o_neg_h (w_nh_f),
        .o_ovf_g (w_og_f),
        .o_ovf_h (w_oh_f)
    );

    // quotient pipelines for the two projective terms
    logic              w_vld_g, w_vld_h;
    logic [31:0]       w_qg, w_qh;
    logic [SBW-1:0]    w_sb_g;
    logic [1:0]        w_sb_h;

    shq_div #(.NW(NW), .DW(DW), .SBW(SBW)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ctl_f.vld),
        .i_num   (w_num_g),
        .i_den   (w_den),
        .i_sb    ({w_og_f, w_ng_f, w_ctl_f.aff, w_crd_f}),
        .o_vld   (w_vld_g),
        .o_quo   (w_qg),
        .o_sb    (w_sb_g)
    );

    shq_div #(.NW(NW), .DW(DW), .SBW(2)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ctl_f.vld),
        .i_num   (w_num_h),
        .i_den   (w_den),
        .i_sb    ({w_oh_f, w_nh_f}),
        .o_vld   (w_vld_h),
        .o_quo   (w_qh),
        .o_sb    (w_sb_h)
    );

    // back: clipping, coefficient products and sums
    shq_pkg::t_ctl w_ctl_b;
    logic          w_aff, w_sat;

    assign w_ctl_b = '{vld: w_vld_g, aff: w_sb_g[6*UW]};

    shq_back #(.UW(UW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_b),
        .i_crd   (w_sb_g[6*UW-1:0]),
        .i_qg    (w_qg),
        .i_ng    (w_sb_g[6*UW+1]),
        .i_og    (w_sb_g[6*UW+2]),
        .i_qh    (w_qh),
        .i_nh    (w_sb_h[0]),
        .i_oh    (w_sb_h[1]),
        .o_vld   (m_axis_tvalid),
        .o_coef  (m_axis_tdata),
        .o_aff   (w_aff),
        .o_sat   (w_sat)
    );

    assign m_axis_tuser = {w_sat, w_aff};

    // the two quotient lanes stay in lockstep
    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld_g == w_vld_h)
        else $error("quotient lanes out of step");

    // affine results carry no projective terms
    a_affine_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[223:192] == 32'd0 && m_axis_tdata[255:224] == 32'd0)
        else $error("affine result with nonzero projective term");

    // coefficient c is a corner column and never negative
    a_c_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[95])
        else $error("negative translation term");

endmodule

// ----- rtl/shq_front.sv -----
module shq_front #(
    parameter int UW = shq_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [UW-1:0]               i_x0,
    input  logic [UW-1:0]               i_y0,
    input  logic [UW-1:0]               i_x1,
    input  logic [UW-1:0]               i_y1,
    input  logic [UW-1:0]               i_x2,
    input  logic [UW-1:0]               i_y2,
    input  logic [UW-1:0]               i_x3,
    input  logic [UW-1:0]               i_y3,
    input  logic [shq_pkg::THR_W-1:0]   i_thr,
    output shq_pkg::t_ctl               o_ctl,
    output logic [6*UW-1:0]             o_crd,     // x0, x1, x3, y0, y1, y3 from low bits
    output logic [2*UW+21:0]            o_num_g,
    output logic [2*UW+21:0]            o_num_h,
    output logic [2*UW+2:0]             o_den,
    output logic                        o_neg_g,
    output logic                        o_neg_h,
    output logic                        o_ovf_g,
    output logic                        o_ovf_h
);

    localparam int DXW = UW + 1;
    localparam int SXW = UW + 3;
    localparam int PW  = 2 * UW + 2;
    localparam int QW  = 2 * UW + 4;
    localparam int DW  = 2 * UW + 3;
    localparam int GW  = 2 * UW + 5;
    localparam int NW  = 2 * UW + 22;
    localparam int CW  = (DW > shq_pkg::THR_W) ? DW : shq_pkg::THR_W;
    localparam int NST = 5;

    // valid and corner coordinates travel alongside the arithmetic
    logic            r_vld [NST];
    logic [6*UW-1:0] r_crd [NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crd[0] <= {i_y3, i_y1, i_y0, i_x3, i_x1, i_x0};
            for (int k = 1; k < NST; k++) r_crd[k] <= r_crd[k-1];
        end
    end

    // stage 1: edge differences and the diagonal sums
    logic signed [DXW-1:0] r_dx1, r_dx2, r_dy1, r_dy2;
    logic signed [SXW-1:0] r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx1 <= $signed({1'b0, i_x1}) - $signed({1'b0, i_x2});
            r_dx2 <= $signed({1'b0, i_x3}) - $signed({1'b0, i_x2});
            r_dy1 <= $signed({1'b0, i_y1}) - $signed({1'b0, i_y2});
            r_dy2 <= $signed({1'b0, i_y3}) - $signed({1'b0, i_y2});
            r_sx  <= $signed({3'b000, i_x0}) - $signed({3'b000, i_x1})
                   + $signed({3'b000, i_x2}) - $signed({3'b000, i_x3});
            r_sy  <= $signed({3'b000, i_y0}) - $signed({3'b000, i_y1})
                   + $signed({3'b000, i_y2}) - $signed({3'b000, i_y3});
        end
    end

    // stage 2: the six cross products
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [QW-1:0] r_pc, r_pd, r_pe, r_pf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= r_dx1 * r_dy2;
            r_pb <= r_dx2 * r_dy1;
            r_pc <= r_sx * r_dy2;
            r_pd <= r_dx2 * r_sy;
            r_pe <= r_dx1 * r_sy;
            r_pf <= r_sx * r_dy1;
        end
    end

    // stage 3: denominator and the two numerators
    logic signed [DW-1:0] r_den3;
    logic signed [GW-1:0] r_gn, r_hn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den3 <= r_pa - r_pb;
            r_gn   <= r_pc - r_pd;
            r_hn   <= r_pe - r_pf;
        end
    end

    // stage 4: magnitudes, quotient signs and the affine decision
    logic [DW-1:0] n_mden;
    logic [GW-1:0] n_mg, n_mh;
    logic [DW-1:0] r_mden;
    logic [GW-1:0] r_mg, r_mh;
    logic          r_ng4, r_nh4, r_aff4;

    always_comb begin
        n_mden = r_den3[DW-1] ? (~r_den3 + 1'b1) : r_den3;
        n_mg   = r_gn[GW-1]   ? (~r_gn + 1'b1)   : r_gn;
        n_mh   = r_hn[GW-1]   ? (~r_hn + 1'b1)   : r_hn;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mden <= n_mden;
            r_mg   <= n_mg;
            r_mh   <= n_mh;
            r_ng4  <= r_gn[GW-1] ^ r_den3[DW-1];
            r_nh4  <= r_hn[GW-1] ^ r_den3[DW-1];
            r_aff4 <= (r_den3 == '0) || (CW'(n_mden) < CW'(i_thr));
        end
    end

    // stage 5: rounding bias and the quotient overflow check
    logic [NW-1:0] n_num_g, n_num_h;
    logic [NW-1:0] r_num_g, r_num_h;
    logic [DW-1:0] r_den5;
    logic          r_ng5, r_nh5, r_og5, r_oh5, r_aff5;

    always_comb begin
        n_num_g = (NW'(r_mg) << shq_pkg::FRAC_W) + NW'(r_mden >> 1);
        n_num_h = (NW'(r_mh) << shq_pkg::FRAC_W) + NW'(r_mden >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num_g <= n_num_g;
            r_num_h <= n_num_h;
            r_den5  <= r_mden;
            r_ng5   <= r_ng4;
            r_nh5   <= r_nh4;
            r_og5   <= DW'(n_num_g >> shq_pkg::QUO_W) >= r_mden;
            r_oh5   <= DW'(n_num_h >> shq_pkg::QUO_W) >= r_mden;
            r_aff5  <= r_aff4;
        end
    end

    assign o_ctl   = '{vld: r_vld[NST-1], aff: r_aff5};
    assign o_crd   = r_crd[NST-1];
    assign o_num_g = r_num_g;
    assign o_num_h = r_num_h;
    assign o_den   = r_den5;
    assign o_neg_g = r_ng5;
    assign o_neg_h = r_nh5;
    assign o_ovf_g = r_og5;
    assign o_ovf_h = r_oh5;

endmodule

// ----- rtl/shq_div.sv -----
module shq_div #(
    parameter int NW  = 50,
    parameter int DW  = 31,
    parameter int SBW = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [NW-1:0]             i_num,
    input  logic [DW-1:0]             i_den,
    input  logic [SBW-1:0]            i_sb,
    output logic                      o_vld,
    output logic [shq_pkg::QUO_W-1:0] o_quo,
    output logic [SBW-1:0]            o_sb
);

    localparam int QW = shq_pkg::QUO_W;

    // one restoring step per stage, quotient bits shift in behind the dividend
    logic            r_vld [QW];
    logic [DW-1:0]   r_rem [QW];
    logic [DW-1:0]   r_den [QW];
    logic [QW-1:0]   r_low [QW];
    logic [SBW-1:0]  r_sb  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          s_vld;
        logic [DW-1:0] s_rem, s_den;
        logic [QW-1:0] s_low;
        logic [SBW-1:0] s_sb;
        logic [DW:0]   s_try, s_diff;
        logic          s_fit;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = DW'(i_num[NW-1:QW]);
            assign s_den = i_den;
            assign s_low = i_num[QW-1:0];
            assign s_sb  = i_sb;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_low = r_low[k-1];
            assign s_sb  = r_sb[k-1];
        end

        assign s_try  = {s_rem, s_low[QW-1]};
        assign s_diff = s_try - {1'b0, s_den};
        assign s_fit  = s_try >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_fit ? s_diff[DW-1:0] : s_try[DW-1:0];
                r_low[k] <= {s_low[QW-2:0], s_fit};
                r_den[k] <= s_den;
                r_sb[k]  <= s_sb;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_low[QW-1];
    assign o_sb  = r_sb[QW-1];

endmodule

// ----- rtl/shq_back.sv -----
module shq_back #(
    parameter int UW = shq_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  shq_pkg::t_ctl               i_ctl,
    input  logic [6*UW-1:0]             i_crd,     // x0, x1, x3, y0, y1, y3 from low bits
    input  logic [shq_pkg::QUO_W-1:0]   i_qg,
    input  logic                        i_ng,
    input  logic                        i_og,
    input  logic [shq_pkg::QUO_W-1:0]   i_qh,
    input  logic                        i_nh,
    input  logic                        i_oh,
    output logic                        o_vld,
    output logic [shq_pkg::NUM_COEF*shq_pkg::COEF_W-1:0] o_coef,  // a .. h from low bits
    output logic                        o_aff,
    output logic                        o_sat
);

    localparam int CFW = shq_pkg::COEF_W;
    localparam int BW  = UW + 1;
    localparam int PW  = CFW + UW + 1;
    localparam int RW  = PW - shq_pkg::RND_SHIFT;
    localparam int SW  = UW + 30;

    logic r_vld [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_ctl.vld;
            for (int k = 1; k < 4; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: clip the quotients to Q16.16, zero them in the affine case
    logic [UW-1:0]           w_x0, w_x1, w_x3, w_y0, w_y1, w_y3;
    logic                    n_cg, n_ch;
    logic signed [CFW-1:0]   n_g, n_h;
    logic signed [CFW-1:0]   r_g1, r_h1;
    logic                    r_cg1, r_ch1, r_aff1;
    logic [6*UW-1:0]         r_crd1;

    assign {w_y3, w_y1, w_y0, w_x3, w_x1, w_x0} = r_crd1;

    always_comb begin
        n_cg = !i_ctl.aff && (i_og || (i_ng ? (i_qg > 32'h8000_0000) : i_qg[CFW-1]));
        n_ch = !i_ctl.aff && (i_oh || (i_nh ? (i_qh > 32'h8000_0000) : i_qh[CFW-1]));
        if (i_ctl.aff) begin
            n_g = '0;
        end else if (i_ng) begin
            n_g = n_cg ? shq_pkg::COEF_MIN : $signed(-i_qg);
        end else begin
            n_g = n_cg ? shq_pkg::COEF_MAX : $signed(i_qg);
        end
        if (i_ctl.aff) begin
            n_h = '0;
        end else if (i_nh) begin
            n_h = n_ch ? shq_pkg::COEF_MIN : $signed(-i_qh);
        end else begin
            n_h = n_ch ? shq_pkg::COEF_MAX : $signed(i_qh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1   <= n_g;
            r_h1   <= n_h;
            r_cg1  <= n_cg;
            r_ch1  <= n_ch;
            r_aff1 <= i_ctl.aff;
            r_crd1 <= i_crd;
        end
    end

    // stage 2: projective products and the affine edge terms
    logic signed [PW-1:0]  r_p2 [4];    // g*x1, h*x3, g*y1, h*y3
    logic signed [BW-1:0]  r_b2 [6];    // a .. f base terms in Q.4
    logic signed [CFW-1:0] r_g2, r_h2;
    logic                  r_cg2, r_ch2, r_aff2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2[0] <= r_g1 * $signed({1'b0, w_x1});
            r_p2[1] <= r_h1 * $signed({1'b0, w_x3});
            r_p2[2] <= r_g1 * $signed({1'b0, w_y1});
            r_p2[3] <= r_h1 * $signed({1'b0, w_y3});
            r_b2[0] <= $signed({1'b0, w_x1}) - $signed({1'b0, w_x0});
            r_b2[1] <= $signed({1'b0, w_x3}) - $signed({1'b0, w_x0});
            r_b2[2] <= $signed({1'b0, w_x0});
            r_b2[3] <= $signed({1'b0, w_y1}) - $signed({1'b0, w_y0});
            r_b2[4] <= $signed({1'b0, w_y3}) - $signed({1'b0, w_y0});
            r_b2[5] <= $signed({1'b0, w_y0});
            r_g2    <= r_g1;
            r_h2    <= r_h1;
            r_cg2   <= r_cg1;
            r_ch2   <= r_ch1;
            r_aff2  <= r_aff1;
        end
    end

    // stage 3: Q.20 to Q.16, nearest with ties away from zero
    logic signed [PW-1:0]  n_t3 [4];
    logic signed [RW-1:0]  r_r3 [6];
    logic signed [BW-1:0]  r_b3 [6];
    logic signed [CFW-1:0] r_g3, r_h3;
    logic                  r_cg3, r_ch3, r_aff3;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_t3[k] = r_p2[k] + (r_p2[k][PW-1] ? PW'(7) : PW'(8));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r3[0] <= n_t3[0][PW-1:shq_pkg::RND_SHIFT];
            r_r3[1] <= n_t3[1][PW-1:shq_pkg::RND_SHIFT];
            r_r3[2] <= '0;
            r_r3[3] <= n_t3[2][PW-1:shq_pkg::RND_SHIFT];
            r_r3[4] <= n_t3[3][PW-1:shq_pkg::RND_SHIFT];
            r_r3[5] <= '0;
            for (int k = 0; k < 6; k++) r_b3[k] <= r_b2[k];
            r_g3   <= r_g2;
            r_h3   <= r_h2;
            r_cg3  <= r_cg2;
            r_ch3  <= r_ch2;
            r_aff3 <= r_aff2;
        end
    end

    // stage 4: coefficient sums, clipping and the output register
    logic signed [SW-1:0]  n_sum [6];
    logic [CFW-1:0]        n_cf  [6];
    logic [5:0]            n_clip;
    logic [CFW-1:0]        r_cf  [shq_pkg::NUM_COEF];
    logic                  r_aff4, r_sat4;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_sum[k] = (SW'(r_b3[k]) <<< shq_pkg::IN_SHIFT) + SW'(r_r3[k]);
            if (n_sum[k] > SW'(shq_pkg::COEF_MAX)) begin
                n_clip[k] = 1'b1;
                n_cf[k]   = shq_pkg::COEF_MAX;
            end else if (n_sum[k] < SW'(shq_pkg::COEF_MIN)) begin
                n_clip[k] = 1'b1;
                n_cf[k]   = shq_pkg::COEF_MIN;
            end else begin
                n_clip[k] = 1'b0;
                n_cf[k]   = n_sum[k][CFW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) r_cf[k] <= n_cf[k];
            r_cf[6] <= r_g3;
            r_cf[7] <= r_h3;
            r_aff4  <= r_aff3;
            r_sat4  <= (|n_clip) | r_cg3 | r_ch3;
        end
    end

    always_comb begin
        for (int k = 0; k < shq_pkg::NUM_COEF; k++) begin
            o_coef[k*CFW +: CFW] = r_cf[k];
        end
    end

    assign o_vld = r_vld[3];
    assign o_aff = r_aff4;
    assign o_sat = r_sat4;

endmodule
